// ===== design/gff_pkg.sv =====
// ----------------------------------------------------------------------------
// gff_pkg
// Shared widths, codes and the result record of the grid flood fill block.
// ----------------------------------------------------------------------------
package gff_pkg;

  // item and result field widths
  localparam int OP_W      = 2;
  localparam int COORD_W   = 8;
  localparam int DATA_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int CHANGED_W = 13;

  // configuration port
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] MAP_WIDTH_RST  = CFG_W'(40);
  localparam logic [CFG_W-1:0] MAP_HEIGHT_RST = CFG_W'(15);

  // grid size defaults
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE = OP_W'(0);
  localparam logic [OP_W-1:0] OP_READ  = OP_W'(1);
  localparam logic [OP_W-1:0] OP_FILL  = OP_W'(2);

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE        = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_OUT_OF_GRID = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_SKIPPED     = STATUS_W'(2);

  typedef struct packed {
    logic [DATA_W-1:0]    cell_type;
    logic [STATUS_W-1:0]  status;
    logic [CHANGED_W-1:0] cells_changed;
  } gff_result_t;

endpackage

// ===== design/gff_if.sv =====
// ----------------------------------------------------------------------------
// gff_in_if / gff_out_if
// Valid/ready channels carrying grid operations in and their results out.
// ----------------------------------------------------------------------------
interface gff_in_if;
  import gff_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           opcode;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic [DATA_W-1:0]         new_type;
  logic [DATA_W-1:0]         target_type;

  modport source (
    output valid, opcode, x_coord, y_coord, new_type, target_type,
    input  ready
  );

  modport sink (
    input  valid, opcode, x_coord, y_coord, new_type, target_type,
    output ready
  );
endinterface

interface gff_out_if;
  import gff_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DATA_W-1:0]    cell_type;
  logic [STATUS_W-1:0]  status;
  logic [CHANGED_W-1:0] cells_changed;

  modport source (
    output valid, cell_type, status, cells_changed,
    input  ready
  );

  modport sink (
    input  valid, cell_type, status, cells_changed,
    output ready
  );
endinterface

// ===== design/gff_ram.sv =====
// ----------------------------------------------------------------------------
// gff_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gff_ram #(
  parameter int DEPTH  = 16,
  parameter int WORD_W = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata_r
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== design/gff_ctrl.sv =====
// ----------------------------------------------------------------------------
// gff_ctrl
// Sequencer: grid clear after reset, read/modify/write of single cells, and
// the stack-driven flood fill over the grid and stack memories.
// ----------------------------------------------------------------------------
module gff_ctrl #(
  parameter int  MAX_WIDTH  = 64,
  parameter int  MAX_HEIGHT = 64,
  localparam int XW         = $clog2(MAX_WIDTH),
  localparam int YW         = $clog2(MAX_HEIGHT),
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW         = $clog2(DEPTH),
  localparam int SW         = XW + YW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gff_in_if.sink                      in_ch,
  gff_out_if.source                   out_ch,
  input  logic [gff_pkg::CFG_W-1:0]   map_width,
  input  logic [gff_pkg::CFG_W-1:0]   map_height,
  output logic                        grid_we,
  output logic [AW-1:0]               grid_waddr,
  output logic [gff_pkg::DATA_W-1:0]  grid_wdata,
  output logic [AW-1:0]               grid_raddr,
  input  logic [gff_pkg::DATA_W-1:0]  grid_rdata,
  output logic                        stk_we,
  output logic [AW-1:0]               stk_waddr,
  output logic [SW-1:0]               stk_wdata,
  output logic [AW-1:0]               stk_raddr,
  input  logic [SW-1:0]               stk_rdata
);
  import gff_pkg::*;

  localparam int SPW = $clog2(DEPTH + 1);
  localparam int XCW = (XW + 1 > COORD_W) ? XW + 1 : COORD_W;
  localparam int YCW = (YW + 1 > COORD_W) ? YW + 1 : COORD_W;

  localparam logic [1:0] DIR_XP = 2'd0;
  localparam logic [1:0] DIR_XM = 2'd1;
  localparam logic [1:0] DIR_YP = 2'd2;
  localparam logic [1:0] DIR_YM = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_POP, S_POPW, S_NBR, S_CHK
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [XW-1:0]      nx_r, nx_nxt, cx_r, cx_nxt;
  logic [YW-1:0]      ny_r, ny_nxt, cy_r, cy_nxt;
  logic [DATA_W-1:0]  nt_r, nt_nxt, tt_r, tt_nxt;
  logic [1:0]         dir_r, dir_nxt;
  logic [SPW-1:0]     sp_r, sp_nxt, sp_dec;
  logic [CHANGED_W-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r;
  gff_result_t        res_r, res_nxt;
  logic               res_load;

  logic               accept, in_ok, in_op_valid;
  logic [XW-1:0]      in_xs;
  logic [YW-1:0]      in_ys;
  logic [XW:0]        cx_inc;
  logic [YW:0]        cy_inc;
  logic               nbr_ok;
  logic [XW-1:0]      nbr_x;
  logic [YW-1:0]      nbr_y;

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                              input logic [YW-1:0] y);
    cell_addr = AW'(y) * AW'(MAX_WIDTH) + AW'(x);
  endfunction

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // start coordinate check against both the configured and the built-in size
  assign in_ok =
    !in_ch.x_coord[COORD_W-1] && !in_ch.y_coord[COORD_W-1] &&
    (XCW'(in_ch.x_coord[COORD_W-2:0]) < XCW'(map_width)) &&
    (XCW'(in_ch.x_coord[COORD_W-2:0]) < XCW'(MAX_WIDTH)) &&
    (YCW'(in_ch.y_coord[COORD_W-2:0]) < YCW'(map_height)) &&
    (YCW'(in_ch.y_coord[COORD_W-2:0]) < YCW'(MAX_HEIGHT));
  assign in_op_valid = (in_ch.opcode == OP_WRITE) || (in_ch.opcode == OP_READ) ||
                       (in_ch.opcode == OP_FILL);
  assign in_xs = XW'(in_ch.x_coord[COORD_W-2:0]);
  assign in_ys = YW'(in_ch.y_coord[COORD_W-2:0]);

  assign sp_dec = sp_r - 1'b1;
  assign cx_inc = (XW+1)'(cx_r) + (XW+1)'(1);
  assign cy_inc = (YW+1)'(cy_r) + (YW+1)'(1);

  // neighbor of the popped cell in the direction under test
  always_comb begin
    nbr_ok = 1'b0;
    nbr_x  = cx_r;
    nbr_y  = cy_r;
    unique case (dir_r)
      DIR_XP: begin
        nbr_ok = (XCW'(cx_inc) < XCW'(map_width)) && (XCW'(cx_inc) < XCW'(MAX_WIDTH));
        nbr_x  = cx_inc[XW-1:0];
      end
      DIR_XM: begin
        nbr_ok = (cx_r != '0);
        nbr_x  = cx_r - 1'b1;
      end
      DIR_YP: begin
        nbr_ok = (YCW'(cy_inc) < YCW'(map_height)) && (YCW'(cy_inc) < YCW'(MAX_HEIGHT));
        nbr_y  = cy_inc[YW-1:0];
      end
      DIR_YM: begin
        nbr_ok = (cy_r != '0);
        nbr_y  = cy_r - 1'b1;
      end
      default: begin
        nbr_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    op_nxt       = op_r;
    nx_nxt       = nx_r;
    ny_nxt       = ny_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    nt_nxt       = nt_r;
    tt_nxt       = tt_r;
    dir_nxt      = dir_r;
    sp_nxt       = sp_r;
    cnt_nxt      = cnt_r;
    res_nxt      = res_r;
    res_load     = 1'b0;
    grid_we      = 1'b0;
    grid_waddr   = cell_addr(nx_r, ny_r);
    grid_wdata   = nt_r;
    grid_raddr   = cell_addr(nbr_x, nbr_y);
    stk_we       = 1'b0;
    stk_waddr    = sp_r[AW-1:0];
    stk_wdata    = {ny_r, nx_r};
    stk_raddr    = sp_dec[AW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        grid_we      = 1'b1;
        grid_waddr   = clr_addr_r;
        grid_wdata   = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        grid_raddr = cell_addr(in_xs, in_ys);
        if (accept) begin
          op_nxt = in_ch.opcode;
          nx_nxt = in_xs;
          ny_nxt = in_ys;
          nt_nxt = in_ch.new_type;
          tt_nxt = in_ch.target_type;
          if (!in_op_valid) begin
            res_load = 1'b1;
            res_nxt  = '0;
          end else if (!in_ok) begin
            res_load       = 1'b1;
            res_nxt        = '0;
            res_nxt.status = ST_OUT_OF_GRID;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        state_nxt = S_IDLE;
        unique case (op_r)
          OP_WRITE: begin
            res_load = 1'b1;
            res_nxt  = '0;
            if (grid_rdata != nt_r) begin
              grid_we               = 1'b1;
              res_nxt.cells_changed = CHANGED_W'(1);
            end
          end
          OP_READ: begin
            res_load          = 1'b1;
            res_nxt           = '0;
            res_nxt.cell_type = grid_rdata;
          end
          OP_FILL: begin
            if (tt_r == nt_r || grid_rdata != tt_r) begin
              res_load       = 1'b1;
              res_nxt        = '0;
              res_nxt.status = ST_SKIPPED;
            end else begin
              // recolor the start cell and make it the only stack entry
              grid_we   = 1'b1;
              stk_we    = 1'b1;
              sp_nxt    = SPW'(1);
              cnt_nxt   = CHANGED_W'(1);
              state_nxt = S_POP;
            end
          end
          default: begin
            res_load = 1'b1;
            res_nxt  = '0;
          end
        endcase
      end
      S_POP: begin
        if (sp_r == '0) begin
          res_load              = 1'b1;
          res_nxt               = '0;
          res_nxt.cells_changed = cnt_r;
          state_nxt             = S_IDLE;
        end else begin
          sp_nxt    = sp_dec;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        cx_nxt    = stk_rdata[XW-1:0];
        cy_nxt    = stk_rdata[SW-1:XW];
        dir_nxt   = DIR_XP;
        state_nxt = S_NBR;
      end
      S_NBR: begin
        if (nbr_ok) begin
          nx_nxt    = nbr_x;
          ny_nxt    = nbr_y;
          state_nxt = S_CHK;
        end else if (dir_r == DIR_YM) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt = dir_r + 1'b1;
        end
      end
      S_CHK: begin
        // the write marks the cell, so it is never pushed twice
        if (grid_rdata == tt_r) begin
          grid_we = 1'b1;
          stk_we  = 1'b1;
          sp_nxt  = sp_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        if (dir_r == DIR_YM) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt   = dir_r + 1'b1;
          state_nxt = S_NBR;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      sp_r       <= sp_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    op_r  <= op_nxt;
    nx_r  <= nx_nxt;
    ny_r  <= ny_nxt;
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    nt_r  <= nt_nxt;
    tt_r  <= tt_nxt;
    dir_r <= dir_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cell_type     = res_r.cell_type;
  assign out_ch.status        = res_r.status;
  assign out_ch.cells_changed = res_r.cells_changed;

endmodule

// ===== design/grid_flood_fill.sv =====
// ----------------------------------------------------------------------------
// grid_flood_fill
// Grid of 8-bit cell types with cell write, cell read and 4-connected fill.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------------
//   in_ch    | in  | valid / ready | opcode, x_coord, y_coord, new_type,
//            |     |               | target_type
//   out_ch   | out | valid / ready | cell_type, status, cells_changed
//   cfg_*    | in  | cfg_we        | cfg_index, cfg_wdata
//
// After reset the grid memory is swept to zero, one cell per cycle, with
// in_ch.ready low; config writes still land. Read and write are accepted
// in S_IDLE and finish in S_LOOK with the registered grid read. Out-of-grid
// and unused opcodes finish in the accept cycle. A fill pops each cell in
// S_POP and S_POPW, then tests each neighbor against the grid edge in S_NBR
// and reads an in-grid one in S_CHK, through the single grid read port; a
// result not yet taken by out_ch holds in_ch.ready low.
// ----------------------------------------------------------------------------
module grid_flood_fill #(
  parameter int MAX_WIDTH  = gff_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gff_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gff_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gff_pkg::CFG_W-1:0]     cfg_wdata,
  gff_in_if.sink                        in_ch,
  gff_out_if.source                     out_ch
);
  import gff_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = XW + YW;

  logic [CFG_W-1:0]  map_width_r, map_height_r;

  logic              grid_we;
  logic [AW-1:0]     grid_waddr, grid_raddr;
  logic [DATA_W-1:0] grid_wdata, grid_rdata;
  logic              stk_we;
  logic [AW-1:0]     stk_waddr, stk_raddr;
  logic [SW-1:0]     stk_wdata, stk_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= MAP_WIDTH_RST;
      map_height_r <= MAP_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:  map_width_r  <= cfg_wdata;
        REG_MAP_HEIGHT: map_height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  gff_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .map_width  (map_width_r),
    .map_height (map_height_r),
    .grid_we    (grid_we),
    .grid_waddr (grid_waddr),
    .grid_wdata (grid_wdata),
    .grid_raddr (grid_raddr),
    .grid_rdata (grid_rdata),
    .stk_we     (stk_we),
    .stk_waddr  (stk_waddr),
    .stk_wdata  (stk_wdata),
    .stk_raddr  (stk_raddr),
    .stk_rdata  (stk_rdata)
  );

  gff_ram #(
    .DEPTH  (DEPTH),
    .WORD_W (DATA_W)
  ) u_grid_ram (
    .clk     (clk),
    .we      (grid_we),
    .waddr   (grid_waddr),
    .wdata   (grid_wdata),
    .raddr   (grid_raddr),
    .rdata_r (grid_rdata)
  );

  // fill stack holds {y, x} of cells still to expand
  gff_ram #(
    .DEPTH  (DEPTH),
    .WORD_W (SW)
  ) u_stack_ram (
    .clk     (clk),
    .we      (stk_we),
    .waddr   (stk_waddr),
    .wdata   (stk_wdata),
    .raddr   (stk_raddr),
    .rdata_r (stk_rdata)
  );

  // an item is taken only when the result slot is free or draining
  a_in_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!out_ch.valid || out_ch.ready))
    else $error("item accepted while result slot is blocked");

  // the grid clear holds off items right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ch.ready)
    else $error("item accepted during grid clear");

  // only a successful read reports a type; failures never report changes
  a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.cell_type != '0 || out_ch.status != ST_DONE)
    |-> out_ch.cells_changed == '0)
    else $error("result reports changed cells with a read or a failure");

  a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.cell_type != '0 |-> out_ch.status == ST_DONE)
    else $error("result reports a type with a failure status");

endmodule
